### design/assert_macros.svh
// Assertion macros shared by the design modules.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check an implication in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/picp_pkg.sv
// Package for the point-in-convex-polygon block: state encoding and
// controller/datapath command and status types. Depends on nothing.
package picp_pkg;

    localparam int unsigned IN_COORD_WIDTH = 31;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_CMP,
        ST_Q_PIVOT_RD,
        ST_Q_PIVOT,
        ST_Q_PROBE_RD,
        ST_Q_PROBE_MUL,
        ST_Q_PROBE,
        ST_Q_LAST_RD,
        ST_Q_LAST,
        ST_Q_A_RD,
        ST_Q_B_RD,
        ST_Q_ORIENT_MUL,
        ST_Q_ORIENT,
        ST_RESULT
    } state_t;

    // Datapath read-address selection
    typedef enum logic [2:0] {
        RA_WRITE,
        RA_PIVOT,
        RA_PROBE,
        RA_LAST,
        RA_EDGE_A,
        RA_EDGE_B
    } raddr_sel_t;

    typedef struct packed {
        logic       capture_item;
        logic       start_polygon;
        logic       write_vertex;
        logic       update_pivot;
        logic       close_check;
        raddr_sel_t raddr_sel;
        logic       read_en;
        logic       latch_pivot;
        logic       search_init;
        logic       probe_mul;
        logic       probe_step;
        logic       last_check;
        logic       latch_a;
        logic       orient_mul;
        logic       orient_done;
        logic       set_result_zero;
    } picp_cmd_t;

    typedef struct packed {
        logic op;
        logic closed;
        logic room;
        logic empty;
        logic pivot_hit;
        logic reject_pivot;
        logic reject_early;
        logic search_done;
    } picp_status_t;

endpackage

### design/picp_stream_if.sv
// Valid/ready stream interface carrying a generic payload.
// Depends on nothing.
interface picp_stream_if #(
    parameter int unsigned WIDTH = 1
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/picp_ctrl.sv
// Controller state machine for the point-in-convex-polygon block.
// Depends on picp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module picp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  picp_pkg::picp_status_t status,
    output picp_pkg::picp_cmd_t    cmd
);

    picp_pkg::state_t state_reg;
    picp_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= picp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence loads and queries
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.raddr_sel = picp_pkg::RA_WRITE;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            picp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture_item = 1'b1;
                    state_next = picp_pkg::ST_LOAD_RD;
                end
            end
            picp_pkg::ST_LOAD_RD:
            begin
                if (status.op == picp_pkg::OP_QUERY)
                begin
                    state_next = status.empty ? picp_pkg::ST_RESULT
                                              : picp_pkg::ST_Q_PIVOT_RD;
                    cmd.set_result_zero = status.empty;
                end
                else
                begin
                    cmd.start_polygon = status.closed;
                    cmd.raddr_sel = picp_pkg::RA_PIVOT;
                    cmd.read_en = 1'b1;
                    state_next = picp_pkg::ST_LOAD_CMP;
                end
            end
            picp_pkg::ST_LOAD_CMP:
            begin
                cmd.write_vertex = status.room;
                cmd.update_pivot = status.room;
                cmd.close_check = 1'b1;
                state_next = picp_pkg::ST_IDLE;
            end
            picp_pkg::ST_Q_PIVOT_RD:
            begin
                cmd.raddr_sel = picp_pkg::RA_PIVOT;
                cmd.read_en = 1'b1;
                state_next = picp_pkg::ST_Q_PIVOT;
            end
            picp_pkg::ST_Q_PIVOT:
            begin
                cmd.latch_pivot = 1'b1;
                cmd.search_init = 1'b1;
                if (status.pivot_hit || status.reject_pivot)
                begin
                    state_next = picp_pkg::ST_RESULT;
                end
                else
                begin
                    state_next = picp_pkg::ST_Q_PROBE_RD;
                end
            end
            picp_pkg::ST_Q_PROBE_RD:
            begin
                if (status.search_done)
                begin
                    cmd.raddr_sel = picp_pkg::RA_LAST;
                    cmd.read_en = 1'b1;
                    state_next = picp_pkg::ST_Q_LAST_RD;
                end
                else
                begin
                    cmd.raddr_sel = picp_pkg::RA_PROBE;
                    cmd.read_en = 1'b1;
                    state_next = picp_pkg::ST_Q_PROBE_MUL;
                end
            end
            picp_pkg::ST_Q_PROBE_MUL:
            begin
                cmd.probe_mul = 1'b1;
                state_next = picp_pkg::ST_Q_PROBE;
            end
            picp_pkg::ST_Q_PROBE:
            begin
                cmd.probe_step = 1'b1;
                state_next = picp_pkg::ST_Q_PROBE_RD;
            end
            picp_pkg::ST_Q_LAST_RD:
            begin
                state_next = picp_pkg::ST_Q_LAST;
            end
            picp_pkg::ST_Q_LAST:
            begin
                cmd.last_check = 1'b1;
                state_next = picp_pkg::ST_Q_A_RD;
            end
            picp_pkg::ST_Q_A_RD:
            begin
                if (status.reject_early)
                begin
                    cmd.set_result_zero = 1'b1;
                    state_next = picp_pkg::ST_RESULT;
                end
                else
                begin
                    cmd.raddr_sel = picp_pkg::RA_EDGE_A;
                    cmd.read_en = 1'b1;
                    state_next = picp_pkg::ST_Q_B_RD;
                end
            end
            picp_pkg::ST_Q_B_RD:
            begin
                cmd.latch_a = 1'b1;
                cmd.raddr_sel = picp_pkg::RA_EDGE_B;
                cmd.read_en = 1'b1;
                state_next = picp_pkg::ST_Q_ORIENT_MUL;
            end
            picp_pkg::ST_Q_ORIENT_MUL:
            begin
                cmd.orient_mul = 1'b1;
                state_next = picp_pkg::ST_Q_ORIENT;
            end
            picp_pkg::ST_Q_ORIENT:
            begin
                cmd.orient_done = 1'b1;
                state_next = picp_pkg::ST_RESULT;
            end
            picp_pkg::ST_RESULT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = picp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = picp_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready,
        state_reg == picp_pkg::ST_LOAD_RD)
    `ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

### design/picp_datapath.sv
// Datapath for the point-in-convex-polygon block: vertex memories,
// pivot tracking, slope binary search and orientation test. Depends on picp_pkg.
module picp_datapath #(
    parameter int unsigned MAX_VERTICES = 256,
    parameter int unsigned COORD_WIDTH  = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_op,
    input  logic signed [picp_pkg::IN_COORD_WIDTH-1:0] item_x,
    input  logic signed [picp_pkg::IN_COORD_WIDTH-1:0] item_y,
    input  logic                                 item_last,
    input  picp_pkg::picp_cmd_t                  cmd,
    output picp_pkg::picp_status_t               status,
    output logic                                 inside_flag
);

    localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned EW = (COORD_WIDTH < picp_pkg::IN_COORD_WIDTH)
                                 ? COORD_WIDTH : picp_pkg::IN_COORD_WIDTH;
    localparam int unsigned DW = EW + 1;        // differences
    localparam int unsigned PW = 2 * DW;        // products
    localparam int unsigned OW = PW + 2;        // orientation sum

    // Coordinates kept at the effective width
    logic                 op_reg, last_reg;
    logic signed [EW-1:0] qx_reg, qy_reg;
    logic signed [EW-1:0] mem_x [MAX_VERTICES];
    logic signed [EW-1:0] mem_y [MAX_VERTICES];
    logic signed [EW-1:0] rd_x_reg, rd_y_reg;
    logic [AW-1:0]        raddr;

    logic [CW-1:0] count_reg;
    logic [AW-1:0] pivot_reg;
    logic          closed_reg;

    logic signed [EW-1:0] px_reg, py_reg;
    logic signed [DW-1:0] qdy_reg, qdx_reg;
    logic [CW-1:0]        lo_reg, len_reg;
    logic signed [PW-1:0] prod_a_reg, prod_b_reg;
    logic                 both_vert_reg;
    logic signed [DW-1:0] ady_reg;
    logic                 reject_reg;
    logic [CW-1:0]        t_reg;
    logic signed [EW-1:0] ax_reg, ay_reg;
    logic signed [PW+1:0] o1_reg, o2_reg, o3_reg;
    logic                 inside_reg;

    // Rotation: (pivot + k) mod count for k <= count
    function automatic logic [AW-1:0] rot(input logic [AW-1:0] piv,
                                          input logic [CW-1:0] k,
                                          input logic [CW-1:0] n);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, piv} + {1'b0, k};
        if (s >= {1'b0, n})
        begin
            s = s - {1'b0, n};
        end
        return s[AW-1:0];
    endfunction

    // Direction from the pivot
    logic signed [DW-1:0] rdy, rdx, cdx;
    logic signed [DW-1:0] qdy_now, qdx_now, qdx_c;
    always_comb
    begin
        rdy = DW'(rd_y_reg) - DW'(py_reg);
        rdx = DW'(rd_x_reg) - DW'(px_reg);
        cdx = rdx;
        if (rdy == '0)
        begin
            cdx = (rdx < 0) ? -DW'(1) : DW'(1);
        end
        qdy_now = DW'(qy_reg) - DW'(rd_y_reg);
        qdx_now = DW'(qx_reg) - DW'(rd_x_reg);
        qdx_c = qdx_now;
        if (qdy_now == '0)
        begin
            qdx_c = (qdx_now < 0) ? -DW'(1) : DW'(1);
        end
    end

    logic [CW-1:0] half, mid;
    assign half = len_reg >> 1;
    assign mid  = lo_reg + half;

    logic [CW-1:0] m_cnt;
    assign m_cnt = count_reg - CW'(1);

    // Select the read address
    always_comb
    begin
        case (cmd.raddr_sel)
            picp_pkg::RA_PIVOT:  raddr = pivot_reg;
            picp_pkg::RA_PROBE:  raddr = rot(pivot_reg, mid + CW'(1), count_reg);
            picp_pkg::RA_LAST:   raddr = rot(pivot_reg, m_cnt, count_reg);
            picp_pkg::RA_EDGE_A: raddr = rot(pivot_reg, t_reg + CW'(1), count_reg);
            picp_pkg::RA_EDGE_B: raddr = rot(pivot_reg, t_reg, count_reg);
            default:             raddr = pivot_reg;
        endcase
    end

    // Vertex memories
    always_ff @(posedge clk)
    begin
        if (cmd.write_vertex)
        begin
            mem_x[count_reg[AW-1:0]] <= qx_reg;
            mem_y[count_reg[AW-1:0]] <= qy_reg;
        end
        if (cmd.read_en)
        begin
            rd_x_reg <= mem_x[raddr];
            rd_y_reg <= mem_y[raddr];
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture_item)
        begin
            op_reg   <= item_op;
            last_reg <= item_last;
            qx_reg   <= item_x[EW-1:0];
            qy_reg   <= item_y[EW-1:0];
        end
    end

    // Polygon bookkeeping
    logic less_than_pivot;
    assign less_than_pivot = (qx_reg < rd_x_reg) ||
                             ((qx_reg == rd_x_reg) && (qy_reg < rd_y_reg));
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            pivot_reg  <= '0;
            closed_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_polygon)
            begin
                count_reg  <= '0;
                pivot_reg  <= '0;
                closed_reg <= 1'b0;
            end
            if (cmd.update_pivot)
            begin
                count_reg <= count_reg + CW'(1);
                if (count_reg == '0 || less_than_pivot)
                begin
                    pivot_reg <= count_reg[AW-1:0];
                end
            end
            // Close on the last mark, also for a dropped vertex
            if (cmd.close_check)
            begin
                closed_reg <= closed_reg | last_reg;
            end
        end
    end

    // Search and orientation
    logic signed [OW-1:0] osum;
    assign osum = OW'(o1_reg) + OW'(o2_reg) + OW'(o3_reg);
    always_ff @(posedge clk)
    begin
        if (cmd.latch_pivot)
        begin
            px_reg  <= rd_x_reg;
            py_reg  <= rd_y_reg;
            qdy_reg <= qdy_now;
            qdx_reg <= qdx_c;
            lo_reg  <= '0;
            len_reg <= m_cnt;
            reject_reg <= 1'b0;
        end
        if (cmd.probe_mul)
        begin
            prod_a_reg    <= qdy_reg * cdx;
            prod_b_reg    <= qdx_reg * rdy;
            both_vert_reg <= (qdx_reg == '0) && (cdx == '0);
            ady_reg       <= rdy;
        end
        if (cmd.probe_step)
        begin
            if (both_vert_reg ? !(qdy_reg < ady_reg) : !(prod_a_reg < prod_b_reg))
            begin
                lo_reg  <= mid + CW'(1);
                len_reg <= len_reg - half - CW'(1);
            end
            else
            begin
                len_reg <= half;
            end
        end
        if (cmd.last_check)
        begin
            t_reg <= lo_reg;
            reject_reg <= (lo_reg == '0) ||
                          ((lo_reg == m_cnt) && !(qdy_reg == rdy && qdx_reg == cdx)) ||
                          ((lo_reg == m_cnt) && (m_cnt == CW'(1)));
            if (lo_reg == m_cnt && qdy_reg == rdy && qdx_reg == cdx)
            begin
                t_reg <= m_cnt - CW'(1);
            end
        end
        if (cmd.latch_a)
        begin
            ax_reg <= rd_x_reg;
            ay_reg <= rd_y_reg;
        end
        if (cmd.orient_mul)
        begin
            o1_reg <= (PW+2)'(ax_reg * (DW'(rd_y_reg) - DW'(qy_reg)));
            o2_reg <= (PW+2)'(rd_x_reg * (DW'(qy_reg) - DW'(ay_reg)));
            o3_reg <= (PW+2)'(qx_reg * (DW'(ay_reg) - DW'(rd_y_reg)));
        end
    end

    // Result
    always_ff @(posedge clk)
    begin
        if (cmd.set_result_zero)
        begin
            inside_reg <= 1'b0;
        end
        else if (cmd.latch_pivot)
        begin
            inside_reg <= (qx_reg == rd_x_reg) && (qy_reg == rd_y_reg);
        end
        else if (cmd.orient_done)
        begin
            inside_reg <= (osum <= 0);
        end
    end

    assign inside_flag = inside_reg;

    assign status.op           = op_reg;
    assign status.closed       = closed_reg;
    assign status.room         = (count_reg < CW'(MAX_VERTICES));
    assign status.empty        = (count_reg == '0);
    assign status.pivot_hit    = (qx_reg == rd_x_reg) && (qy_reg == rd_y_reg);
    assign status.reject_pivot = (qx_reg < rd_x_reg) || (count_reg < CW'(3));
    assign status.reject_early = reject_reg;
    assign status.search_done  = (len_reg == '0);

endmodule

### design/point_in_convex_polygon.sv
// Point-in-convex-polygon block, top level.
//
// Channel in (valid/ready): op, x, y, last. A load request (op=0) stores
// a vertex of a counterclockwise convex polygon; last closes it, and the next
// load starts a new polygon. Vertices past MAX_VERTICES are dropped.
// A query request (op=1) returns one item on channel out: the inside flag.
// Loads give no result.
// A load passes through the read and compare states. A query on an empty
// polygon goes straight to its result; one that hits the pivot, lies left of
// it or meets a polygon of fewer than three vertices ends after the pivot
// check; otherwise a binary search over fan slopes (a memory read and a
// multiply per probe) runs, then an orientation test unless no wedge is found.
// After a result is taken the block returns to idle before the next request.
// One request is in flight at a time; in ready is low while it is worked on.
// A result stays on out until taken; a stalled receiver stalls the block.
// Reset clears the vertex count, pivot and closed flag; the vertex memory
// is not cleared, and a value read from it is never used before it is written.
module point_in_convex_polygon #(
    parameter int unsigned MAX_VERTICES = 256,
    parameter int unsigned COORD_WIDTH  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    picp_stream_if.sink   in_ch,
    picp_stream_if.source out_ch
);

    picp_pkg::picp_cmd_t    cmd;
    picp_pkg::picp_status_t status;
    logic                   inside_flag;

    picp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    picp_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_op     (in_ch.data[0]),
        .item_x      (in_ch.data[31:1]),
        .item_y      (in_ch.data[62:32]),
        .item_last   (in_ch.data[63]),
        .cmd         (cmd),
        .status      (status),
        .inside_flag (inside_flag)
    );

    assign out_ch.data = inside_flag;

endmodule
